/* hdl/rptg_pkg.sv */
// shared types and constants for the round phase transition guard
// command, result and configuration encodings; no dependencies
package rptg_pkg;

  // default width of the ticket counters
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned TICKET_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROUND_NUMBER = 2'd0,
    CFG_ROUND_HEIGHT = 2'd1,
    CFG_TICKET_LIMIT = 2'd2,
    CFG_NONE         = 2'd3
  } cfg_idx_t;

  // command kinds
  typedef enum logic [2:0] {
    CMD_REPLAY      = 3'd0,
    CMD_VIEW_STEP   = 3'd1,
    CMD_COMMIT      = 3'd2,
    CMD_AVAIL       = 3'd3,
    CMD_FREEZE      = 3'd4,
    CMD_AGGREGATE   = 3'd5,
    CMD_ABORT       = 3'd6,
    UNKNOWN_COMMAND = 3'd7
  } mode_t;

  // round phases
  typedef enum logic [2:0] {
    PH_OPEN       = 3'd0,
    PH_COMMITTED  = 3'd1,
    PH_AVAILABLE  = 3'd2,
    PH_ELIGIBLE   = 3'd3,
    PH_AGGREGATED = 3'd4,
    PH_ABORTED    = 3'd5
  } phase_t;

  // rejection reasons
  typedef enum logic [3:0] {
    ERR_NONE         = 4'd0,
    ERR_ROUND        = 4'd1,
    ERR_HEIGHT       = 4'd2,
    ERR_VIEW         = 4'd3,
    ERR_PHASE        = 4'd4,
    ERR_TERMINAL     = 4'd5,
    ERR_TICKETS      = 4'd6,
    ERR_AVAILABILITY = 4'd7,
    ERR_EMPTY        = 4'd8,
    ERR_UNKNOWN      = 4'd9,
    ERR_OVERFLOW     = 4'd10
  } err_t;

  // command transaction payload
  typedef struct packed {
    mode_t             mode;
    logic [WORD_W-1:0] cmd_view;
    logic [WORD_W-1:0] cmd_round;
    logic [WORD_W-1:0] cmd_height;
    logic [WORD_W-1:0] digest_w0;
    logic [WORD_W-1:0] digest_w1;
    logic [WORD_W-1:0] digest_w2;
    logic [WORD_W-1:0] digest_w3;
  } cmd_t;

  // result transaction payload
  typedef struct packed {
    logic                accepted;
    err_t                error_code;
    phase_t              phase_out;
    logic [WORD_W-1:0]   view_out;
    logic [WORD_W-1:0]   sequence_out;
    logic [TICKET_W-1:0] committed_out;
    logic [TICKET_W-1:0] available_out;
    logic [WORD_W-1:0]   root_w0;
    logic [WORD_W-1:0]   root_w1;
    logic [WORD_W-1:0]   root_w2;
    logic [WORD_W-1:0]   root_w3;
  } res_t;

endpackage

/* hdl/rptg_cmd_if.sv */
// command channel of the round phase transition guard
// valid/ready handshake with a cmd_t payload; depends on rptg_pkg
interface rptg_cmd_if;
  logic          valid;
  logic          ready;
  rptg_pkg::cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/rptg_res_if.sv */
// result channel of the round phase transition guard
// valid/ready handshake with a res_t payload; depends on rptg_pkg
interface rptg_res_if;
  logic          valid;
  logic          ready;
  rptg_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/round_phase_transition_guard_unit.sv */
// round phase transition guard: checks one command per cycle against round state
// unless a result stalls; depends on rptg_pkg, rptg_cmd_if and rptg_res_if
//
//  channel | direction | handshake          | payload
//  cmd     | in        | cmd.valid/ready    | mode, view, round, height, digest words
//  res     | out       | res.valid/ready    | accepted, error code, state after the command
//  cfg     | in        | cfg_we             | cfg_index, cfg_data (no read-back)
//
// a command is registered on entry and judged against the round state; its
// result is registered when the result slot is free or being taken and is
// offered from then on; one command is taken every cycle while results are
// taken; the state updates with the result register, so the next command sees it.
// rst clears the round state, the configuration and both stage valids.
// a stalled result holds the judge stage, which holds the entry register in turn.
module round_phase_transition_guard_unit #(
  parameter int unsigned COUNT_WIDTH = rptg_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rptg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rptg_pkg::WORD_W-1:0]         cfg_data,
  rptg_cmd_if.sink                            cmd,
  rptg_res_if.source                          res
);

  localparam int unsigned CMP_W =
    (COUNT_WIDTH > rptg_pkg::TICKET_W) ? COUNT_WIDTH : rptg_pkg::TICKET_W;

  // configuration
  logic [rptg_pkg::WORD_W-1:0]   round_number;
  logic [rptg_pkg::WORD_W-1:0]   round_height;
  logic [rptg_pkg::TICKET_W-1:0] ticket_limit;

  // round state
  rptg_pkg::phase_t            phase;
  logic [rptg_pkg::WORD_W-1:0] view;
  logic [rptg_pkg::WORD_W-1:0] seq;
  logic [COUNT_WIDTH-1:0]      committed;
  logic [COUNT_WIDTH-1:0]      available;
  logic [rptg_pkg::WORD_W-1:0] root [4];

  // entry register and result register
  logic           s1_valid;
  rptg_pkg::cmd_t s1;
  logic           res_valid;
  rptg_pkg::res_t res_data;

  logic advance;

  // next values of the judge stage
  rptg_pkg::err_t              err;
  logic                        bump;
  rptg_pkg::phase_t            phase_next;
  logic [rptg_pkg::WORD_W-1:0] view_next;
  logic [rptg_pkg::WORD_W-1:0] seq_next;
  logic [COUNT_WIDTH-1:0]      committed_next;
  logic [COUNT_WIDTH-1:0]      available_next;
  logic                        root_load;
  logic                        commit_ok;

  // handshake
  assign advance   = s1_valid && (!res_valid || res.ready);
  assign cmd.ready = !s1_valid || advance;
  assign res.valid = res_valid;
  assign res.data  = res_data;

  // command checks and transition rules
  always_comb begin
    err            = rptg_pkg::ERR_NONE;
    bump           = 1'b0;
    phase_next     = phase;
    view_next      = view;
    committed_next = committed;
    available_next = available;
    root_load      = 1'b0;
    if (s1.cmd_round != round_number) begin
      err = rptg_pkg::ERR_ROUND;
    end else if (s1.cmd_height != round_height) begin
      err = rptg_pkg::ERR_HEIGHT;
    end else if (s1.mode != rptg_pkg::CMD_VIEW_STEP && s1.cmd_view != view) begin
      err = rptg_pkg::ERR_VIEW;
    end else if (s1.mode == rptg_pkg::CMD_REPLAY) begin
      // replay changes nothing and keeps the sequence
      if (phase != rptg_pkg::PH_OPEN) err = rptg_pkg::ERR_PHASE;
    end else if (phase == rptg_pkg::PH_AGGREGATED || phase == rptg_pkg::PH_ABORTED) begin
      err = rptg_pkg::ERR_TERMINAL;
    end else begin
      bump = 1'b1;
      unique case (s1.mode)
        rptg_pkg::CMD_VIEW_STEP: begin
          if (view == '1 || s1.cmd_view != view + 64'd1) err = rptg_pkg::ERR_VIEW;
          view_next = s1.cmd_view;
        end
        rptg_pkg::CMD_COMMIT: begin
          if (phase != rptg_pkg::PH_OPEN && phase != rptg_pkg::PH_COMMITTED) begin
            err = rptg_pkg::ERR_PHASE;
          end else if (CMP_W'(committed) >= CMP_W'(ticket_limit) || committed == '1) begin
            err = rptg_pkg::ERR_TICKETS;
          end
          committed_next = committed + COUNT_WIDTH'(1);
          phase_next     = rptg_pkg::PH_COMMITTED;
        end
        rptg_pkg::CMD_AVAIL: begin
          if (phase != rptg_pkg::PH_COMMITTED && phase != rptg_pkg::PH_AVAILABLE) begin
            err = rptg_pkg::ERR_PHASE;
          end else if (available >= committed) begin
            err = rptg_pkg::ERR_AVAILABILITY;
          end
          available_next = available + COUNT_WIDTH'(1);
          phase_next     = rptg_pkg::PH_AVAILABLE;
        end
        rptg_pkg::CMD_FREEZE: begin
          if (phase != rptg_pkg::PH_AVAILABLE) begin
            err = rptg_pkg::ERR_PHASE;
          end else if (available == '0) begin
            err = rptg_pkg::ERR_EMPTY;
          end
          phase_next = rptg_pkg::PH_ELIGIBLE;
        end
        rptg_pkg::CMD_AGGREGATE: begin
          if (phase != rptg_pkg::PH_ELIGIBLE) err = rptg_pkg::ERR_PHASE;
          phase_next = rptg_pkg::PH_AGGREGATED;
          root_load  = 1'b1;
        end
        rptg_pkg::CMD_ABORT: begin
          phase_next = rptg_pkg::PH_ABORTED;
        end
        default: begin
          err = rptg_pkg::ERR_UNKNOWN;
        end
      endcase
      if (err == rptg_pkg::ERR_NONE && seq == '1) err = rptg_pkg::ERR_OVERFLOW;
    end
    seq_next = bump ? seq + 64'd1 : seq;
  end

  assign commit_ok = (err == rptg_pkg::ERR_NONE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      round_number <= '0;
      round_height <= '0;
      ticket_limit <= '0;
    end else if (cfg_we) begin
      unique case (rptg_pkg::cfg_idx_t'(cfg_index))
        rptg_pkg::CFG_ROUND_NUMBER: round_number <= cfg_data;
        rptg_pkg::CFG_ROUND_HEIGHT: round_height <= cfg_data;
        rptg_pkg::CFG_TICKET_LIMIT: ticket_limit <= cfg_data[rptg_pkg::TICKET_W-1:0];
        default: ;
      endcase
    end
  end

  // entry register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
    if (cmd.ready && cmd.valid) s1 <= cmd.data;
  end

  // round state, updated only by an accepted command
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= rptg_pkg::PH_OPEN;
      view      <= '0;
      seq       <= '0;
      committed <= '0;
      available <= '0;
      for (int i = 0; i < 4; i++) root[i] <= '0;
    end else if (advance && commit_ok) begin
      phase     <= phase_next;
      view      <= view_next;
      seq       <= seq_next;
      committed <= committed_next;
      available <= available_next;
      if (root_load) begin
        root[0] <= s1.digest_w0;
        root[1] <= s1.digest_w1;
        root[2] <= s1.digest_w2;
        root[3] <= s1.digest_w3;
      end
    end
  end

  // result register shows the state after the command
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
    if (advance) begin
      res_data.accepted      <= commit_ok;
      res_data.error_code    <= err;
      res_data.phase_out     <= commit_ok ? phase_next : phase;
      res_data.view_out      <= commit_ok ? view_next : view;
      res_data.sequence_out  <= commit_ok ? seq_next : seq;
      res_data.committed_out <= rptg_pkg::TICKET_W'(commit_ok ? committed_next : committed);
      res_data.available_out <= rptg_pkg::TICKET_W'(commit_ok ? available_next : available);
      res_data.root_w0       <= (commit_ok && root_load) ? s1.digest_w0 : root[0];
      res_data.root_w1       <= (commit_ok && root_load) ? s1.digest_w1 : root[1];
      res_data.root_w2       <= (commit_ok && root_load) ? s1.digest_w2 : root[2];
      res_data.root_w3       <= (commit_ok && root_load) ? s1.digest_w3 : root[3];
    end
  end

endmodule
